@@ sv/rrpg_pkg.sv @@
package rrpg_pkg;

	localparam int MAX_TEAMS_DEF = 32;

	localparam int TEAM_W  = 7;
	localparam int COUNT_W = 6;
	localparam int ROUND_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] REG_TEAM_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_TEAM   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_ROUND = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DONE,
		ST_PAIR,
		ST_ADV
	} state_t;

	typedef struct packed {
		logic restart;
		logic idx_clr;
		logic idx_inc;
		logic load_pair;
		logic load_done;
		logic advance;
	} cmd_t;

	typedef struct packed {
		logic no_sched;
		logic skip;
		logic at_end;
		logic out_free;
	} status_t;

endpackage

@@ sv/rrpg_ctrl.sv @@
module rrpg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              restart,
	output logic              in_ready,
	input  rrpg_pkg::status_t sts,
	output rrpg_pkg::cmd_t    cmd
);

	rrpg_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrpg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rrpg_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = rrpg_pkg::ST_SETUP;
			end
			rrpg_pkg::ST_SETUP: begin
				state_nxt = sts.no_sched ? rrpg_pkg::ST_DONE : rrpg_pkg::ST_PAIR;
			end
			rrpg_pkg::ST_DONE: begin
				if (sts.out_free) state_nxt = rrpg_pkg::ST_IDLE;
			end
			rrpg_pkg::ST_PAIR: begin
				if ((sts.skip || sts.out_free) && sts.at_end) state_nxt = rrpg_pkg::ST_ADV;
			end
			rrpg_pkg::ST_ADV: begin
				state_nxt = rrpg_pkg::ST_IDLE;
			end
			default: state_nxt = rrpg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			rrpg_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.restart = in_valid && restart;
			end
			rrpg_pkg::ST_SETUP: begin
				cmd.idx_clr = 1'b1;
			end
			rrpg_pkg::ST_DONE: begin
				cmd.load_done = sts.out_free;
			end
			rrpg_pkg::ST_PAIR: begin
				// a bye pair is passed over without touching the output
				cmd.load_pair = !sts.skip && sts.out_free;
				cmd.idx_inc   = sts.skip || sts.out_free;
			end
			rrpg_pkg::ST_ADV: begin
				cmd.advance = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

@@ sv/rrpg_dp.sv @@
module rrpg_dp #(
	parameter int MAX_TEAMS = rrpg_pkg::MAX_TEAMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rrpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rrpg_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  rrpg_pkg::cmd_t                      cmd,
	output rrpg_pkg::status_t                   sts,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [rrpg_pkg::TEAM_W-1:0]         home_team,
	output logic [rrpg_pkg::TEAM_W-1:0]         away_team,
	output logic [rrpg_pkg::ROUND_W-1:0]        round_index,
	output logic                                last_in_round,
	output logic                                schedule_done
);

	// wide enough for the ring size, which is at most MAX_TEAMS + 1
	localparam int SW = $clog2(MAX_TEAMS + 2);

	logic [rrpg_pkg::COUNT_W-1:0] team_count_q;
	logic [rrpg_pkg::TEAM_W-1:0]  first_team_q;
	logic                         double_round_q;
	logic [SW-1:0]                rnd_q;
	logic                         leg_q;
	logic                         fin_q;
	logic [SW-1:0]                idx_q;

	logic [SW-1:0] n_eff, size, half, size_m1;
	logic          odd;
	logic [SW:0]   da, db;
	logic [SW-1:0] a_off, b_off;
	logic [SW-1:0] bye_pos, bye_pair;
	logic [rrpg_pkg::TEAM_W-1:0] team_a, team_b;
	logic          swap;
	logic [rrpg_pkg::TEAM_W-1:0] rnd_sum;
	logic          is_last;
	logic          out_free;

	always_comb begin
		if ({1'b0, team_count_q} > 7'(MAX_TEAMS)) n_eff = SW'(MAX_TEAMS);
		else n_eff = SW'(team_count_q);
		odd     = n_eff[0];
		size    = n_eff + SW'(odd);
		half    = size >> 1;
		size_m1 = size - SW'(1);
	end

	// ring contents follow from the rotation count: slot k >= 1 holds
	// 1 + ((k - 1 - rnd) mod (size - 1)), slot 0 holds offset 0
	always_comb begin
		da = {1'b0, idx_q} - {1'b0, rnd_q} - (SW+1)'(1);
		if (da[SW]) da = da + {1'b0, size_m1};
		db = {1'b0, size} - (SW+1)'(2) - {1'b0, idx_q} - {1'b0, rnd_q};
		if (db[SW]) db = db + {1'b0, size_m1};
		a_off = (idx_q == '0) ? '0 : da[SW-1:0] + SW'(1);
		b_off = db[SW-1:0] + SW'(1);
		team_a = first_team_q + 7'(a_off);
		team_b = first_team_q + 7'(b_off);
	end

	// the bye (offset size - 1 when the count is odd) sits in slot rnd, or in the
	// last slot on round zero
	always_comb begin
		bye_pos  = (rnd_q == '0) ? size_m1 : rnd_q;
		bye_pair = (bye_pos < half) ? bye_pos : size_m1 - bye_pos;
		is_last  = (idx_q == half - SW'(1)) ||
		           (odd && (bye_pair == half - SW'(1)) && (idx_q == half - SW'(2)));
		swap     = rnd_q[0] ^ leg_q;
		rnd_sum  = 7'(rnd_q) + (leg_q ? 7'(size_m1) : 7'd0);
	end

	assign out_free = !out_valid || out_ready;

	always_comb begin
		sts.no_sched = (n_eff < SW'(2)) || fin_q;
		sts.skip     = odd && (idx_q == bye_pair);
		sts.at_end   = idx_q == half - SW'(1);
		sts.out_free = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			team_count_q   <= '0;
			first_team_q   <= '0;
			double_round_q <= 1'b1;
			rnd_q          <= '0;
			leg_q          <= 1'b0;
			fin_q          <= 1'b0;
			idx_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rrpg_pkg::REG_TEAM_COUNT:   team_count_q   <= cfg_data[rrpg_pkg::COUNT_W-1:0];
					rrpg_pkg::REG_FIRST_TEAM:   first_team_q   <= cfg_data;
					rrpg_pkg::REG_DOUBLE_ROUND: double_round_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cfg_we || cmd.restart) begin
				rnd_q <= '0;
				leg_q <= 1'b0;
				fin_q <= 1'b0;
			end else if (cmd.advance) begin
				if (rnd_q + SW'(1) >= size_m1) begin
					rnd_q <= '0;
					if (!leg_q && double_round_q) leg_q <= 1'b1;
					else fin_q <= 1'b1;
				end else begin
					rnd_q <= rnd_q + SW'(1);
				end
			end
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + SW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_pair || cmd.load_done) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_done) begin
			home_team     <= '0;
			away_team     <= '0;
			round_index   <= '0;
			last_in_round <= 1'b1;
			schedule_done <= 1'b1;
		end else if (cmd.load_pair) begin
			home_team     <= swap ? team_b : team_a;
			away_team     <= swap ? team_a : team_b;
			round_index   <= rnd_sum[rrpg_pkg::ROUND_W-1:0];
			last_in_round <= is_last;
			schedule_done <= 1'b0;
		end
	end

endmodule

@@ sv/round_robin_pairing_generator.sv @@
// channel | signals                      | payload
// --------+------------------------------+------------------------------------------
// in      | in_valid / in_ready          | restart
// out     | out_valid / out_ready        | home_team away_team round_index
//         |                              | last_in_round schedule_done
// cfg     | cfg_we (no wait)             | cfg_index cfg_data
//
// A request goes through setup, a walk over the pairs of one round and the ring
// advance; the walk loads one pair per cycle into the output register while the
// output is free, and a bye pair still takes its step. A done result skips the walk.
// Reset clears the config registers to team_count 0, first_team 0,
// double_round 1 and starts the schedule at round zero.
// A stalled output holds the pair walk; the next request is taken while the
// last result of the previous one still waits.
module round_robin_pairing_generator #(
	parameter int MAX_TEAMS = rrpg_pkg::MAX_TEAMS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rrpg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rrpg_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [rrpg_pkg::TEAM_W-1:0]       home_team,
	output logic [rrpg_pkg::TEAM_W-1:0]       away_team,
	output logic [rrpg_pkg::ROUND_W-1:0]      round_index,
	output logic                              last_in_round,
	output logic                              schedule_done
);

	rrpg_pkg::cmd_t    cmd;
	rrpg_pkg::status_t sts;

	rrpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.restart  (restart),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrpg_dp #(
		.MAX_TEAMS (MAX_TEAMS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.home_team     (home_team),
		.away_team     (away_team),
		.round_index   (round_index),
		.last_in_round (last_in_round),
		.schedule_done (schedule_done)
	);

endmodule

@@ sv/rrpg_checker.sv @@
module rrpg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [rrpg_pkg::TEAM_W-1:0]       home_team,
	input logic [rrpg_pkg::TEAM_W-1:0]       away_team,
	input logic [rrpg_pkg::ROUND_W-1:0]      round_index,
	input logic                              last_in_round,
	input logic                              schedule_done
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(home_team) &&
		$stable(away_team) && $stable(round_index) &&
		$stable(last_in_round) && $stable(schedule_done))
		else $error("stalled result changed");

	// done result is the single closing one with zero fields
	a_done_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && schedule_done |-> last_in_round && home_team == '0 &&
		away_team == '0 && round_index == '0)
		else $error("malformed done result");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	// a participant never meets itself
	a_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !schedule_done |-> home_team != away_team)
		else $error("pair with identical participants");

endmodule

bind round_robin_pairing_generator rrpg_checker u_rrpg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.home_team     (home_team),
	.away_team     (away_team),
	.round_index   (round_index),
	.last_in_round (last_in_round),
	.schedule_done (schedule_done)
);

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;

	localparam int CYCLE_LIMIT = 600_000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int TOTAL_REQUESTS = 250;
	localparam logic [rrpg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef logic [rrpg_pkg::TEAM_W-1:0] team_t;
	typedef logic [rrpg_pkg::ROUND_W-1:0] round_t;
	typedef logic [rrpg_pkg::CFG_DATA_W-1:0] cfg_word_t;

	typedef struct packed {
		team_t  home;
		team_t  away;
		round_t rnd;
		logic   last;
		logic   done;
	} fixture_t;

	// Tracks the circle-method schedule and the pairings still owed by the block.
	class fixture_tracker;
		logic [rrpg_pkg::COUNT_W-1:0] team_cnt;
		team_t base_id;
		bit two_legs;
		int unsigned ring [rrpg_pkg::MAX_TEAMS_DEF+1];
		int unsigned round_in_leg;
		bit return_leg;
		bit exhausted;
		fixture_t due[$];
		int errors;

		function new();
			errors = 0;
			team_cnt = '0;
			base_id = '0;
			two_legs = 1'b1;
			rewind();
		endfunction

		function void rewind();
			for (int i = 0; i <= rrpg_pkg::MAX_TEAMS_DEF; i++) ring[i] = i;
			round_in_leg = 0;
			return_leg = 1'b0;
			exhausted = 1'b0;
		endfunction

		function int unsigned teams();
			return (team_cnt > rrpg_pkg::MAX_TEAMS_DEF) ? rrpg_pkg::MAX_TEAMS_DEF : team_cnt;
		endfunction

		// any write, known index or not, rewinds the schedule
		function void set_reg(logic [rrpg_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data);
			case (idx)
				rrpg_pkg::REG_TEAM_COUNT: team_cnt = data[rrpg_pkg::COUNT_W-1:0];
				rrpg_pkg::REG_FIRST_TEAM: base_id = data;
				rrpg_pkg::REG_DOUBLE_ROUND: two_legs = data[0];
				default: ;
			endcase
			rewind();
		endfunction

		function void note_request(bit fresh);
			int unsigned n, size, rounds, a, b, tail;
			bit flip;
			bit have;
			fixture_t f;
			fixture_t pend;
			if (fresh) rewind();
			n = teams();
			size = n + (n % 2);
			f = '0;
			pend = '0;
			have = 1'b0;
			if (n < 2 || exhausted) begin
				f.last = 1'b1;
				f.done = 1'b1;
				due = {due, f};
				return;
			end
			rounds = size - 1;
			f.rnd = round_t'(round_in_leg + (return_leg ? rounds : 0));
			flip = ((round_in_leg % 2) != 0) ^ return_leg;
			for (int i = 0; i < size / 2; i++) begin
				a = ring[i];
				b = ring[size - 1 - i];
				if (a >= n || b >= n) continue;   // pair with the bye slot
				f.home = team_t'(base_id + (flip ? b : a));
				f.away = team_t'(base_id + (flip ? a : b));
				// hold one pair back so the closing one can be flagged
				if (have) due = {due, pend};
				pend = f;
				have = 1'b1;
			end
			pend.last = 1'b1;
			due = {due, pend};

			// slot 0 stays, the last slot moves into slot 1
			if (size > 2) begin
				tail = ring[size - 1];
				for (int i = size - 1; i > 1; i--) ring[i] = ring[i - 1];
				ring[1] = tail;
			end
			round_in_leg++;
			if (round_in_leg >= rounds) begin
				round_in_leg = 0;
				if (!return_leg && two_legs) return_leg = 1'b1;
				else exhausted = 1'b1;
			end
		endfunction

		function void check_fixture(fixture_t got);
			fixture_t want;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: %0d/%0d r%0d l%0b d%0b",
					$time, got.home, got.away, got.rnd, got.last, got.done);
				return;
			end
			want = due.pop_front();
			if (got !== want) begin
				errors++;
				$display("%0t: expected %0d/%0d r%0d l%0b d%0b, actual %0d/%0d r%0d l%0b d%0b",
					$time, want.home, want.away, want.rnd, want.last, want.done,
					got.home, got.away, got.rnd, got.last, got.done);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [rrpg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	cfg_word_t cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	team_t home_team;
	team_t away_team;
	round_t round_index;
	logic last_in_round;
	logic schedule_done;

	fixture_tracker sched = new();
	bit hold_req = 1'b0;
	int requests_sent = 0;
	int cycles = 0;

	round_robin_pairing_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.home_team(home_team),
		.away_team(away_team),
		.round_index(round_index),
		.last_in_round(last_in_round),
		.schedule_done(schedule_done)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sched.check_fixture({home_team, away_team, round_index, last_in_round, schedule_done});
	end

	// output side: stretches of steady, random, sparse and toggling ready
	initial begin
		int mode, len;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(5, 80);
			repeat (len) begin
				@(posedge clk);
				if (hold_req) begin
					out_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
					hold_req = 1'b0;
				end else begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= ~out_ready;
					endcase
				end
			end
		end
	end

	task automatic send(bit fresh);
		in_valid <= 1'b1;
		restart <= fresh;
		do @(posedge clk); while (!in_ready);
		sched.note_request(fresh);
		requests_sent++;
	endtask

	task automatic cfg_write(logic [rrpg_pkg::CFG_IDX_W-1:0] idx, cfg_word_t data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sched.set_reg(idx, data);
	endtask

	// wait for every owed pairing, then let the ring rotation finish
	task automatic settle();
		in_valid <= 1'b0;
		while (sched.due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic setup(int tc, int ft, int dr);
		settle();
		cfg_write(rrpg_pkg::REG_TEAM_COUNT, cfg_word_t'(tc));
		cfg_write(rrpg_pkg::REG_FIRST_TEAM, cfg_word_t'(ft));
		cfg_write(rrpg_pkg::REG_DOUBLE_ROUND, cfg_word_t'(dr));
		cfg_we <= 1'b0;
	endtask

	task automatic run_items(int cnt, int restart_pct);
		int left, gap;
		left = $urandom_range(1, 12);
		for (int i = 0; i < cnt; i++) begin
			send($urandom_range(0, 99) < restart_pct);
			left--;
			if (left == 0 && i < cnt - 1) begin
				left = $urandom_range(1, 12);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
	endtask

	function automatic int pick_count();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0) return $urandom_range(0, 1);
		if (sel == 1) return $urandom_range(11, 32);
		if (sel == 2) return $urandom_range(33, 63);
		return $urandom_range(2, 10);
	endfunction

	initial begin
		int n, span, cnt;
		bit any_write;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: no teams, so done results only
		send(1'b0);
		send(1'b1);
		settle();
		cfg_write(rrpg_pkg::REG_TEAM_COUNT, cfg_word_t'(1));
		cfg_we <= 1'b0;
		send(1'b0);

		// two teams, ids wrap past 127, both legs then exhausted, then restart
		setup(2, 127, 1);
		repeat (4) send(1'b0);
		send(1'b1);

		// odd count with bye, single leg
		setup(3, 120, 0);
		repeat (4) send(1'b0);

		// unknown register index only rewinds
		settle();
		cfg_write(REG_UNUSED, 7'h7f);
		cfg_we <= 1'b0;
		send(1'b0);

		// oversized count is capped at the ring maximum
		setup(63, 96, 1);
		repeat (3) send(1'b0);

		setup(5, 1, 1);
		repeat (2) send(1'b0);
		send(1'b1);

		// full-size rounds against a receiver that holds off for a long time
		setup(32, $urandom_range(0, 127), 1);
		hold_req = 1'b1;
		repeat (8) send(1'b0);
		settle();
		run_items(6, 0);

		while (requests_sent < TOTAL_REQUESTS) begin
			settle();
			any_write = 1'b0;
			if ($urandom_range(0, 9) < 7) begin
				cfg_write(rrpg_pkg::REG_TEAM_COUNT, cfg_word_t'(pick_count()));
				any_write = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				cfg_write(rrpg_pkg::REG_FIRST_TEAM, cfg_word_t'($urandom_range(0, 127)));
				any_write = 1'b1;
			end
			if ($urandom_range(0, 2) == 0) begin
				cfg_write(rrpg_pkg::REG_DOUBLE_ROUND, cfg_word_t'($urandom_range(0, 1)));
				any_write = 1'b1;
			end
			if ($urandom_range(0, 7) == 0) begin
				cfg_write(REG_UNUSED, cfg_word_t'($urandom_range(0, 127)));
				any_write = 1'b1;
			end
			if (any_write) cfg_we <= 1'b0;

			// long enough to usually run the schedule to its end
			n = sched.teams();
			if (n < 2) span = 3;
			else span = (n + (n % 2) - 1) * (sched.two_legs ? 2 : 1) + 2;
			cnt = $urandom_range(1, span);
			if (cnt > TOTAL_REQUESTS - requests_sent) cnt = TOTAL_REQUESTS - requests_sent;
			run_items(cnt, 6);
		end

		settle();
		if (sched.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
